@@ rtl/sorted_key_table_search_macros.svh @@
// Assertion macros for the sorted key table search block.
// Bodies expect i_clk and i_rst_n in the including module's scope.
`ifndef SORTED_KEY_TABLE_SEARCH_MACROS_SVH
`define SORTED_KEY_TABLE_SEARCH_MACROS_SVH

// Expression holds on every clock edge out of reset.
`define SKTS_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SKTS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define SKTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/skts_pkg.sv @@
// Shared types, widths and codes for the sorted key table search block.
// No dependencies.
`timescale 1ns / 1ps

package skts_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed word field widths
    localparam int KEY_W       = 21;
    localparam int POS_W       = 6;
    localparam int CNT_OUT_W   = 7;
    localparam int STATUS_W    = 2;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [CNT_W:0]       t_sum;
    typedef logic [KEY_W-1:0]     t_key;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [CNT_OUT_W-1:0] t_cnt_out;
    typedef logic [STATUS_W-1:0]  t_status;

    localparam t_cnt FILL_MAX = t_cnt'(TABLE_DEPTH);

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SHIFT,
        S_PLACE
    } t_state;

endpackage

@@ rtl/skts_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module skts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and register the read word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/sorted_key_table_search.sv @@
// Top level of the sorted key table: sequencer, shared compare unit, key RAM.
// Depends on skts_pkg, skts_ram and sorted_key_table_search_macros.svh.
//
//  channel   handshake               word
//  -------   ---------------------   ----------------------------------------------
//  command   start && !busy          i_command, i_key
//  result    o_done (one cycle)      o_found, o_position, o_status, o_entry_count
//
// A search probes one entry per cycle through the single RAM read port; its result
// is registered.
// An insert runs a binary search for the slot past its equal keys, then shifts the
// larger keys up one entry per cycle and writes the key; its result is registered as
// for a search.
// A full-table insert and an empty-table search answer on the next cycle.
// Reset clears the fill count and the sequencer; the key RAM needs no clearing.
// Results appear for one cycle on o_done; the receiver cannot stall them.
`timescale 1ns / 1ps
`include "sorted_key_table_search_macros.svh"

module sorted_key_table_search (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        i_command,
    input  logic [skts_pkg::KEY_W-1:0]  i_key,
    output logic                        busy,
    output logic                        o_done,
    output logic                        o_found,
    output logic [skts_pkg::POS_W-1:0]  o_position,
    output logic [skts_pkg::STATUS_W-1:0] o_status,
    output logic [skts_pkg::CNT_OUT_W-1:0] o_entry_count
);

    // Midpoint of the half-open range [lo, he): floor((lo + he - 1) / 2)
    function automatic skts_pkg::t_idx mid_of(input skts_pkg::t_cnt lo,
                                              input skts_pkg::t_cnt he);
        skts_pkg::t_sum s;
        s = skts_pkg::t_sum'(lo) + skts_pkg::t_sum'(he) - skts_pkg::t_sum'(1);
        return s[skts_pkg::IDX_W:1];
    endfunction

    skts_pkg::t_state r_state, n_state;
    logic             r_cmd, n_cmd;
    skts_pkg::t_key   r_key, n_key;
    skts_pkg::t_cnt   r_lo, n_lo;
    skts_pkg::t_cnt   r_he, n_he;
    skts_pkg::t_idx   r_mid, n_mid;
    skts_pkg::t_idx   r_slot, n_slot;
    skts_pkg::t_idx   r_dst, n_dst;
    skts_pkg::t_cnt   r_fill, n_fill;
    logic             r_done, n_done;
    logic             r_found, n_found;
    skts_pkg::t_idx   r_pos, n_pos;
    skts_pkg::t_status r_status, n_status;
    skts_pkg::t_cnt   r_count, n_count;

    skts_pkg::t_idx   rd_addr;
    skts_pkg::t_key   rd_data;
    logic             wr_en;
    skts_pkg::t_idx   wr_addr;
    skts_pkg::t_key   wr_data;

    // Shared compare unit and range update
    logic             key_eq;
    logic             key_gt;
    skts_pkg::t_cnt   cmp_lo;
    skts_pkg::t_cnt   cmp_he;
    logic             cmp_more;
    logic             accept;
    logic             table_full;

    assign accept     = start && (r_state == skts_pkg::S_IDLE);
    assign table_full = (r_fill == skts_pkg::FILL_MAX);
    assign key_eq     = (rd_data == r_key);
    assign key_gt     = (rd_data > r_key);
    assign cmp_lo     = key_gt ? r_lo : (skts_pkg::t_cnt'(r_mid) + skts_pkg::t_cnt'(1));
    assign cmp_he     = key_gt ? skts_pkg::t_cnt'(r_mid) : r_he;
    assign cmp_more   = (cmp_lo < cmp_he);

    skts_ram #(
        .WIDTH (skts_pkg::KEY_W),
        .DEPTH (skts_pkg::TABLE_DEPTH)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            skts_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_command == skts_pkg::CMD_INSERT && table_full) begin
                        n_state = skts_pkg::S_IDLE;
                    end else if (r_fill != '0) begin
                        n_state = skts_pkg::S_CMP;
                    end else if (i_command == skts_pkg::CMD_INSERT) begin
                        n_state = skts_pkg::S_PLACE;
                    end
                end
            end
            skts_pkg::S_CMP: begin
                if (r_cmd == skts_pkg::CMD_SEARCH && key_eq) begin
                    n_state = skts_pkg::S_IDLE;
                end else if (cmp_more) begin
                    n_state = skts_pkg::S_CMP;
                end else if (r_cmd == skts_pkg::CMD_SEARCH) begin
                    n_state = skts_pkg::S_IDLE;
                end else if (cmp_lo == r_fill) begin
                    n_state = skts_pkg::S_PLACE;
                end else begin
                    n_state = skts_pkg::S_SHIFT;
                end
            end
            skts_pkg::S_SHIFT: begin
                if (r_dst - skts_pkg::t_idx'(1) == r_slot) begin
                    n_state = skts_pkg::S_PLACE;
                end
            end
            skts_pkg::S_PLACE: begin
                n_state = skts_pkg::S_IDLE;
            end
            default: begin
                n_state = skts_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result word
    always_comb begin
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_lo     = r_lo;
        n_he     = r_he;
        n_mid    = r_mid;
        n_slot   = r_slot;
        n_dst    = r_dst;
        n_fill   = r_fill;
        n_done   = 1'b0;
        n_found  = r_found;
        n_pos    = r_pos;
        n_status = r_status;
        n_count  = r_count;
        rd_addr  = r_mid;
        wr_en    = 1'b0;
        wr_addr  = r_slot;
        wr_data  = r_key;
        unique case (r_state)
            skts_pkg::S_IDLE: begin
                if (accept) begin
                    // Latch the word and issue the first probe
                    n_cmd   = i_command;
                    n_key   = i_key;
                    n_lo    = '0;
                    n_he    = r_fill;
                    n_mid   = mid_of('0, r_fill);
                    rd_addr = mid_of('0, r_fill);
                    n_slot  = '0;
                    if (i_command == skts_pkg::CMD_INSERT && table_full) begin
                        n_done   = 1'b1;
                        n_found  = 1'b0;
                        n_pos    = '0;
                        n_status = skts_pkg::ST_FULL;
                        n_count  = r_fill;
                    end else if (i_command == skts_pkg::CMD_SEARCH && r_fill == '0) begin
                        n_done   = 1'b1;
                        n_found  = 1'b0;
                        n_pos    = '0;
                        n_status = skts_pkg::ST_NOT_FOUND;
                        n_count  = r_fill;
                    end
                end
            end
            skts_pkg::S_CMP: begin
                // Narrow the range and probe the next midpoint
                n_lo    = cmp_lo;
                n_he    = cmp_he;
                n_mid   = mid_of(cmp_lo, cmp_he);
                rd_addr = cmp_more ? mid_of(cmp_lo, cmp_he)
                                   : skts_pkg::t_idx'(r_fill - skts_pkg::t_cnt'(1));
                n_slot  = skts_pkg::t_idx'(cmp_lo);
                n_dst   = skts_pkg::t_idx'(r_fill);
                if (r_cmd == skts_pkg::CMD_SEARCH) begin
                    if (key_eq) begin
                        n_done   = 1'b1;
                        n_found  = 1'b1;
                        n_pos    = r_mid;
                        n_status = skts_pkg::ST_OK;
                        n_count  = r_fill;
                    end else if (!cmp_more) begin
                        n_done   = 1'b1;
                        n_found  = 1'b0;
                        n_pos    = '0;
                        n_status = skts_pkg::ST_NOT_FOUND;
                        n_count  = r_fill;
                    end
                end
            end
            skts_pkg::S_SHIFT: begin
                // Move one key up and read the one below it
                wr_en   = 1'b1;
                wr_addr = r_dst;
                wr_data = rd_data;
                rd_addr = r_dst - skts_pkg::t_idx'(2);
                n_dst   = r_dst - skts_pkg::t_idx'(1);
            end
            skts_pkg::S_PLACE: begin
                // Drop the new key into its slot
                wr_en    = 1'b1;
                wr_addr  = r_slot;
                wr_data  = r_key;
                n_fill   = r_fill + skts_pkg::t_cnt'(1);
                n_done   = 1'b1;
                n_found  = 1'b0;
                n_pos    = r_slot;
                n_status = skts_pkg::ST_OK;
                n_count  = r_fill + skts_pkg::t_cnt'(1);
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skts_pkg::S_IDLE;
            r_fill  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_lo     <= n_lo;
        r_he     <= n_he;
        r_mid    <= n_mid;
        r_slot   <= n_slot;
        r_dst    <= n_dst;
        r_found  <= n_found;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_count  <= n_count;
    end

    assign busy          = (r_state != skts_pkg::S_IDLE);
    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_position    = skts_pkg::t_pos'(r_pos);
    assign o_status      = r_status;
    assign o_entry_count = skts_pkg::t_cnt_out'(r_count);

    `SKTS_ASSERT_HOLDS(a_fill_bound, r_fill <= skts_pkg::FILL_MAX, "fill count over depth")
    `SKTS_ASSERT_IMPLIES(a_done_has_cause, o_done, $past(busy || start), "result without work")
    `SKTS_ASSERT_IMPLIES(a_count_tracks_fill, o_done, r_count == r_fill, "entry count mismatch")
    `SKTS_ASSERT_IMPLIES(a_shift_above_slot, r_state == skts_pkg::S_SHIFT, r_dst > r_slot, "shift below slot")
    `SKTS_ASSERT_NEXT(a_place_grows, r_state == skts_pkg::S_PLACE, r_fill == $past(r_fill) + skts_pkg::t_cnt'(1), "fill not advanced")

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for sorted_key_table_search: queued insert/search words, in-bench table model.
// Depends on skts_pkg and the sorted_key_table_search RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_OPS     = 1380;

    typedef struct packed {
        logic           command;
        skts_pkg::t_key key;
    } t_table_op;

    typedef struct packed {
        logic               found;
        skts_pkg::t_pos     position;
        skts_pkg::t_status  status;
        skts_pkg::t_cnt_out entry_count;
    } t_lookup_reply;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic               i_command     = skts_pkg::CMD_INSERT;
    skts_pkg::t_key     i_key         = '0;
    logic               busy;
    logic               o_done;
    logic               o_found;
    skts_pkg::t_pos     o_position;
    skts_pkg::t_status  o_status;
    skts_pkg::t_cnt_out o_entry_count;

    // Stimulus, expectations and bookkeeping
    t_table_op      pending_ops[$];
    t_lookup_reply  expected_replies[$];
    skts_pkg::t_key held_keys[$];
    int             total_ops;
    int             ops_accepted = 0;
    int             mismatch_count = 0;
    int             burst_left = 1;
    int             gap_left = 0;
    int             idle_cycles = 0;

    // Model of the table contents
    skts_pkg::t_key model_keys[skts_pkg::TABLE_DEPTH];
    int             model_fill = 0;

    sorted_key_table_search u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_command     (i_command),
        .i_key         (i_key),
        .busy          (busy),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Apply one word to the table model and return the reply it must produce
    function automatic t_lookup_reply table_apply(input logic cmd, input skts_pkg::t_key key);
        t_lookup_reply reply;
        int slot;
        int lo;
        int hi;
        int mid;
        reply = '{found: 1'b0, position: '0, status: skts_pkg::ST_OK, entry_count: '0};
        if (cmd == skts_pkg::CMD_INSERT) begin
            if (model_fill >= skts_pkg::TABLE_DEPTH) begin
                reply.status = skts_pkg::ST_FULL;
            end else begin
                // new key lands after every key equal to it
                slot = 0;
                while (slot < model_fill && model_keys[slot] <= key) slot++;
                for (int i = model_fill; i > slot; i--) model_keys[i] = model_keys[i-1];
                model_keys[slot] = key;
                model_fill++;
                reply.position = skts_pkg::t_pos'(slot);
            end
        end else begin
            reply.status = skts_pkg::ST_NOT_FOUND;
            lo = 0;
            hi = model_fill - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (model_keys[mid] == key) begin
                    reply.found    = 1'b1;
                    reply.position = skts_pkg::t_pos'(mid);
                    reply.status   = skts_pkg::ST_OK;
                    break;
                end
                if (model_keys[mid] > key) hi = mid - 1;
                else lo = mid + 1;
            end
        end
        reply.entry_count = skts_pkg::t_cnt_out'(model_fill);
        return reply;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Queue a word and track which keys the table will hold
    task automatic queue_op(input logic cmd, input skts_pkg::t_key key);
        t_table_op op;
        op = '{command: cmd, key: key};
        pending_ops.insert(pending_ops.size(), op);
        if (cmd == skts_pkg::CMD_INSERT && held_keys.size() < skts_pkg::TABLE_DEPTH)
            held_keys.insert(held_keys.size(), key);
    endtask

    function automatic skts_pkg::t_key held_key();
        return held_keys[$urandom_range(0, held_keys.size() - 1)];
    endfunction

    // Mix of extremes, a narrow band for duplicates, near misses and full-range keys
    function automatic skts_pkg::t_key draw_key();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? '1 : '0;
            1, 2: return skts_pkg::t_key'($urandom_range(0, 15));
            3: begin
                if (held_keys.size() == 0) return skts_pkg::t_key'($urandom());
                return $urandom_range(0, 1) ? held_key() + skts_pkg::t_key'(1)
                                            : held_key() - skts_pkg::t_key'(1);
            end
            default: return skts_pkg::t_key'($urandom());
        endcase
    endfunction

    // Driver: hold the word until taken, then issue the next after any gap
    always @(posedge i_clk) begin : driver
        t_table_op op;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_replies.insert(expected_replies.size(),
                                        table_apply(i_command, i_key));
                ops_accepted++;
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    op = pending_ops.pop_front();
                    i_command <= op.command;
                    i_key     <= op.key;
                    start     <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each reply against the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_lookup_reply want;
        if (i_rst_n && o_done) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("reply with nothing outstanding, entry_count", o_entry_count, 0);
            end else begin
                want = expected_replies.pop_front();
                if (o_found !== want.found)
                    report_mismatch("found", o_found, want.found);
                if (o_position !== want.position)
                    report_mismatch("position", o_position, want.position);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_entry_count !== want.entry_count)
                    report_mismatch("entry_count", o_entry_count, want.entry_count);
            end
        end
    end

    // Watchdog: stop a run that stops moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles = 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_key_table_search test failed");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    initial begin
        int             insert_odds;
        skts_pkg::t_key key;

        // Directed: empty table, extremes, duplicates, misses, alternating bits
        queue_op(skts_pkg::CMD_SEARCH, '0);
        queue_op(skts_pkg::CMD_SEARCH, '1);
        queue_op(skts_pkg::CMD_INSERT, '1);
        queue_op(skts_pkg::CMD_INSERT, '0);
        queue_op(skts_pkg::CMD_INSERT, '1);
        queue_op(skts_pkg::CMD_SEARCH, '1);
        queue_op(skts_pkg::CMD_SEARCH, '0);
        queue_op(skts_pkg::CMD_INSERT, skts_pkg::t_key'(7));
        queue_op(skts_pkg::CMD_INSERT, skts_pkg::t_key'(7));
        queue_op(skts_pkg::CMD_INSERT, skts_pkg::t_key'(7));
        queue_op(skts_pkg::CMD_SEARCH, skts_pkg::t_key'(7));
        queue_op(skts_pkg::CMD_SEARCH, skts_pkg::t_key'(8));
        queue_op(skts_pkg::CMD_SEARCH, skts_pkg::t_key'(1));
        queue_op(skts_pkg::CMD_INSERT, skts_pkg::t_key'(21'h0AAAAA));
        queue_op(skts_pkg::CMD_INSERT, skts_pkg::t_key'(21'h155555));
        queue_op(skts_pkg::CMD_SEARCH, skts_pkg::t_key'(21'h155555));
        queue_op(skts_pkg::CMD_SEARCH, skts_pkg::t_key'(21'h0AAAAA));
        queue_op(skts_pkg::CMD_SEARCH, skts_pkg::t_key'(21'h1FFFFE));
        queue_op(skts_pkg::CMD_INSERT, skts_pkg::t_key'(8));
        queue_op(skts_pkg::CMD_SEARCH, skts_pkg::t_key'(8));

        // Random: fill the table gradually, then keep probing it and hitting full
        for (int n = 0; n < RANDOM_OPS; n++) begin
            insert_odds = (held_keys.size() < skts_pkg::TABLE_DEPTH) ? 12 : 8;
            if ($urandom_range(1, insert_odds) == 1) begin
                queue_op(skts_pkg::CMD_INSERT, draw_key());
            end else begin
                key = ($urandom_range(0, 7) < 5) ? held_key() : draw_key();
                queue_op(skts_pkg::CMD_SEARCH, key);
            end
        end
        total_ops = pending_ops.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all words taken, all replies seen, then a quiet stretch
        while (ops_accepted != total_ops) @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("sorted_key_table_search test passed");
        end else begin
            $display("sorted_key_table_search test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/skts_pkg.sv
rtl/skts_ram.sv
rtl/sorted_key_table_search.sv
tb/tb_top.sv
